// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the limiter.
// Each macro expects a clock named i_clk in scope; ASSERT_CLK also expects an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/mfrl_pkg.sv
// Package for the message flood and repeat limiter: payload, configuration and state types,
// verdict codes and register indexes. It depends on nothing.
package mfrl_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_WINDOW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOD_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOD_WINDOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUTE_TICKS    = 3'd4;

    localparam logic [7:0]  COUNT_MAX = 8'hFF;
    localparam logic [31:0] TICK_MAX  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        VERDICT_PASS   = 2'd0,
        VERDICT_MUTED  = 2'd1,
        VERDICT_REPEAT = 2'd2,
        VERDICT_FLOOD  = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [31:0] now_tick;
        logic [4:0]  message_code;
    } t_in_item;

    typedef struct packed {
        logic     allowed;
        t_verdict verdict;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  repeat_limit;
        logic [15:0] repeat_window;
        logic [7:0]  flood_limit;
        logic [15:0] flood_window;
        logic [15:0] mute_ticks;
    } t_cfg;

    typedef struct packed {
        logic [31:0] mute_until;
        logic [4:0]  last_code;
        logic [31:0] repeat_stamp;
        logic [7:0]  repeat_count;
        logic [31:0] window_start;
        logic [7:0]  window_count;
    } t_state;

    function automatic logic [7:0] sat_inc8(input logic [7:0] value);
        sat_inc8 = (value == COUNT_MAX) ? COUNT_MAX : value + 8'd1;
    endfunction

endpackage

// File: hdl/mfrl_decide.sv
// Decision logic of the limiter: from the current state, the configuration and one request
// it forms the verdict and the next state. Depends on mfrl_pkg.
module mfrl_decide (
    input  mfrl_pkg::t_cfg     i_cfg,
    input  mfrl_pkg::t_state   i_state,
    input  mfrl_pkg::t_in_item i_item,
    output mfrl_pkg::t_state   o_state,
    output mfrl_pkg::t_out_item o_result
);
    import mfrl_pkg::*;

    logic [32:0] mute_sum;
    logic [31:0] mute_end;
    logic [31:0] rep_elapsed;
    logic [31:0] win_elapsed;
    logic [7:0]  rep_count_inc;
    logic [7:0]  win_count_inc;
    logic [31:0] mute_cur;
    logic        busted;
    t_verdict    verdict;

    // A new mute ends at now plus the mute length, held at the top of the tick range.
    assign mute_sum      = {1'b0, i_item.now_tick} + {17'd0, i_cfg.mute_ticks};
    assign mute_end      = mute_sum[32] ? TICK_MAX : mute_sum[31:0];
    assign rep_elapsed   = i_item.now_tick - i_state.repeat_stamp;
    assign win_elapsed   = i_item.now_tick - i_state.window_start;
    assign rep_count_inc = sat_inc8(i_state.repeat_count);
    assign win_count_inc = sat_inc8(i_state.window_count);

    always_comb begin
        o_state  = i_state;
        verdict  = VERDICT_PASS;
        busted   = 1'b0;
        mute_cur = i_state.mute_until;

        if (i_cfg.repeat_limit != 8'd0) begin
            if (mute_cur != 32'd0 && mute_cur > i_item.now_tick) begin
                verdict = VERDICT_MUTED;
            end else begin
                mute_cur = 32'd0;
                if (i_state.last_code == i_item.message_code) begin
                    if (rep_elapsed < {16'd0, i_cfg.repeat_window}) begin
                        o_state.repeat_count = rep_count_inc;
                        if (rep_count_inc == i_cfg.repeat_limit) begin
                            mute_cur = mute_end;
                            busted   = 1'b1;
                        end
                    end else begin
                        o_state.repeat_count = 8'd0;
                    end
                end
                if (busted) begin
                    verdict = VERDICT_REPEAT;
                end else begin
                    o_state.last_code    = i_item.message_code;
                    o_state.repeat_stamp = i_item.now_tick;
                end
            end
        end

        if (verdict == VERDICT_PASS && i_cfg.flood_limit != 8'd0) begin
            if (mute_cur != 32'd0 && mute_cur > i_item.now_tick) begin
                verdict = VERDICT_MUTED;
            end else begin
                mute_cur = 32'd0;
                if (i_state.window_count == 8'd0) begin
                    o_state.window_start = i_item.now_tick;
                    o_state.window_count = 8'd1;
                end else begin
                    o_state.window_count = win_count_inc;
                    if (win_elapsed < {16'd0, i_cfg.flood_window}) begin
                        if (win_count_inc >= i_cfg.flood_limit) begin
                            mute_cur = mute_end;
                            verdict  = VERDICT_FLOOD;
                        end
                    end else begin
                        o_state.window_count = 8'd0;
                    end
                end
            end
        end

        o_state.mute_until = mute_cur;
        o_result.allowed   = (verdict == VERDICT_PASS);
        o_result.verdict   = verdict;
    end

endmodule

// File: hdl/message_flood_and_repeat_limiter.sv
// Top level of the message flood and repeat limiter: handshakes, configuration registers,
// limiter state and the result register. Depends on mfrl_pkg, mfrl_decide, assert_macros.svh.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_in_valid / o_in_ready     i_in_data  (now_tick, message_code)
//   verdict   out        o_out_valid / i_out_ready   o_out_data (allowed, verdict)
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request is taken per cycle while the verdict channel is not stalled; each request is
// registered in the input register, then decided and registered in the result register,
// from which its verdict is offered.
// The limiter state is updated as a request leaves the input register, so the next request
// sees it at once; the combinational decision logic sets that rate.
// A stalled verdict holds the result register; the input register still takes one more
// request, and only then does o_in_ready fall.
// Synchronous active-low reset clears the configuration registers, the state and the valids.
// Configuration writes are always taken; indexes beyond the register list are ignored.
`include "assert_macros.svh"

module message_flood_and_repeat_limiter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  mfrl_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output mfrl_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mfrl_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [mfrl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mfrl_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      advance;

    // The request in the input register moves on when the result register is free
    // or is being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    mfrl_decide u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REPEAT_LIMIT:  r_cfg.repeat_limit  <= i_cfg_data[7:0];
                CFG_REPEAT_WINDOW: r_cfg.repeat_window <= i_cfg_data;
                CFG_FLOOD_LIMIT:   r_cfg.flood_limit   <= i_cfg_data[7:0];
                CFG_FLOOD_WINDOW:  r_cfg.flood_window  <= i_cfg_data;
                CFG_MUTE_TICKS:    r_cfg.mute_ticks    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Limiter state and the two valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    `ASSERT_RST(a_out_idle_after_reset, !i_rst_n |=> !o_out_valid, "verdict valid after reset")
    `ASSERT_CLK(a_allowed_matches_verdict,
        o_out_valid |-> (o_out_data.allowed == (o_out_data.verdict == VERDICT_PASS)),
        "allowed flag disagrees with verdict")
    `ASSERT_CLK(a_no_state_change_when_disabled,
        (advance && r_cfg.repeat_limit == 8'd0 && r_cfg.flood_limit == 8'd0) |=> $stable(r_state),
        "state changed with both checks disabled")
    `ASSERT_CLK(a_repeat_mute_keeps_stamp,
        (advance && n_out_item.verdict == VERDICT_REPEAT)
            |=> ($stable(r_state.last_code) && $stable(r_state.repeat_stamp)),
        "repeat mute moved the repeat stamp")
    `ASSERT_CLK(a_ready_when_empty, !r_in_valid |-> o_in_ready, "input stage empty but not ready")

endmodule

// File: dv/message_flood_and_repeat_limiter_tb.sv
// Self-checking testbench for message_flood_and_repeat_limiter, the repeat and flood limiter.
// Depends on mfrl_pkg and the RTL only. A local predictor tracks the limiter state, and the
// verdict returned for every request is checked field by field against it.
module message_flood_and_repeat_limiter_tb;
    import mfrl_pkg::*;

    // Index that lies beyond the register list. The block must ignore writes to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 3'd7;

    // No new phase of random traffic starts once this many requests have been sent.
    localparam int REQUEST_BUDGET = 1880;
    // From the first phase begun after this many requests, neither side adds random gaps or stalls.
    localparam int CALM_FROM = 1750;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b1;
    logic      cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    message_flood_and_repeat_limiter dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Local copy of the limiter: its registers and its state, both zero as after reset.
    t_cfg     limiter_cfg = '0;
    t_state   limiter_state = '0;

    // Verdicts predicted for accepted requests, oldest first.
    t_verdict pending_verdicts[$];

    int  failures = 0;
    int  requests_sent = 0;
    int  settings_used = 0;
    int  verdict_tally[4] = '{0, 0, 0, 0};
    bit  gaps_on = 1'b1;
    bit  calm_tail = 1'b0;
    logic [31:0] tick_cursor = 32'd20000;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Counters stick at their maximum rather than wrapping.
    function automatic logic [7:0] bump_count(input logic [7:0] count);
        return (count == COUNT_MAX) ? COUNT_MAX : count + 8'd1;
    endfunction

    // A mute ends mute_ticks after now. An end past the top of the tick range is held at the
    // largest tick.
    function automatic void arm_mute(input logic [31:0] now);
        logic [32:0] stop;
        stop = {1'b0, now} + {17'd0, limiter_cfg.mute_ticks};
        limiter_state.mute_until = stop[32] ? TICK_MAX : stop[31:0];
    endfunction

    // True while a mute is still running. A mute that has run out is cleared here, and a
    // stored end of zero already means that no mute is running.
    function automatic logic mute_running(input logic [31:0] now);
        if (limiter_state.mute_until != 32'd0) begin
            if (limiter_state.mute_until > now)
                return 1'b1;
            limiter_state.mute_until = 32'd0;
        end
        return 1'b0;
    endfunction

    // Works out the verdict for one request and moves the local state on. The repeat check
    // runs first; the flood check runs only if the repeat check let the request through.
    // Elapsed time is taken modulo 2^32, so a stamp earlier than the stored one lands far
    // outside any window, and a zero window never holds anything.
    function automatic t_verdict judge_request(input logic [31:0] now, input logic [4:0] code);
        t_verdict    verdict;
        logic [31:0] elapsed;
        logic        caught;
        verdict = VERDICT_PASS;
        caught = 1'b0;
        if (limiter_cfg.repeat_limit != 8'd0) begin
            if (mute_running(now)) begin
                verdict = VERDICT_MUTED;
            end else begin
                if (limiter_state.last_code == code) begin
                    elapsed = now - limiter_state.repeat_stamp;
                    if (elapsed < {16'd0, limiter_cfg.repeat_window}) begin
                        limiter_state.repeat_count = bump_count(limiter_state.repeat_count);
                        if (limiter_state.repeat_count == limiter_cfg.repeat_limit) begin
                            arm_mute(now);
                            caught = 1'b1;
                        end
                    end else begin
                        limiter_state.repeat_count = 8'd0;
                    end
                end
                // A caught repeat leaves the stored code and stamp as they were.
                if (caught) begin
                    verdict = VERDICT_REPEAT;
                end else begin
                    limiter_state.last_code = code;
                    limiter_state.repeat_stamp = now;
                end
            end
        end
        if (verdict == VERDICT_PASS && limiter_cfg.flood_limit != 8'd0) begin
            if (mute_running(now)) begin
                verdict = VERDICT_MUTED;
            end else if (limiter_state.window_count == 8'd0) begin
                // An empty count opens a new window without checking the limit.
                limiter_state.window_start = now;
                limiter_state.window_count = 8'd1;
            end else begin
                limiter_state.window_count = bump_count(limiter_state.window_count);
                elapsed = now - limiter_state.window_start;
                if (elapsed < {16'd0, limiter_cfg.flood_window}) begin
                    if (limiter_state.window_count >= limiter_cfg.flood_limit) begin
                        arm_mute(now);
                        verdict = VERDICT_FLOOD;
                    end
                end else begin
                    limiter_state.window_count = 8'd0;
                end
            end
        end
        return verdict;
    endfunction

    // ------------------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------------------

    // Offers one request and waits for its transfer. Valid stays high after the transfer,
    // so that back-to-back requests need no second assignment in the same step. A random
    // gap drops valid first; besides settle_idle, this is the only place the sender idles.
    task automatic send_request(input logic [31:0] tick, input logic [4:0] code);
        t_in_item req;
        req.now_tick = tick;
        req.message_code = code;
        if (gaps_on && !calm_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // The transfer happened at this edge: predict its verdict now, in transfer order.
        pending_verdicts.push_back(judge_request(tick, code));
        requests_sent++;
    endtask

    // Drops valid and waits until every verdict is back, plus a little margin, so that the
    // block is idle before its registers change.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write. The local copy takes the value at the transfer and keeps only the
    // register's own width.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_REPEAT_LIMIT:  limiter_cfg.repeat_limit = value[7:0];
            CFG_REPEAT_WINDOW: limiter_cfg.repeat_window = value;
            CFG_FLOOD_LIMIT:   limiter_cfg.flood_limit = value[7:0];
            CFG_FLOOD_WINDOW:  limiter_cfg.flood_window = value;
            CFG_MUTE_TICKS:    limiter_cfg.mute_ticks = value;
            default: ;
        endcase
    endtask

    // Writes all five registers. The limits are 8 bits wide, and their upper data byte may
    // carry junk that the block has to drop. Now and then an unused index is written too.
    task automatic program_limits(input logic [15:0] repeat_limit,
                                  input logic [15:0] repeat_window,
                                  input logic [15:0] flood_limit,
                                  input logic [15:0] flood_window,
                                  input logic [15:0] mute_ticks);
        write_reg(CFG_REPEAT_LIMIT, repeat_limit);
        write_reg(CFG_REPEAT_WINDOW, repeat_window);
        write_reg(CFG_FLOOD_LIMIT, flood_limit);
        write_reg(CFG_FLOOD_WINDOW, flood_window);
        write_reg(CFG_MUTE_TICKS, mute_ticks);
        if (settings_used == 0 || $urandom_range(0, 3) == 0)
            write_reg(CFG_NO_REGISTER, 16'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // The receiver stalls in random bursts between runs of readiness, some of them long.
    // In the calm tail it stays ready.
    initial begin : drive_out_ready
        int run;
        @(posedge i_clk);
        forever begin
            out_ready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            if (!calm_tail) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    // Every verdict transfer is held against the oldest prediction.
    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict with no request pending: allowed %0b verdict %0d",
                         $time, o_out_data.allowed, o_out_data.verdict);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out_data.allowed !== (want == VERDICT_PASS)) begin
                    $display("%0t: allowed mismatch: expected %0b, actual %0b",
                             $time, want == VERDICT_PASS, o_out_data.allowed);
                    failures++;
                end
                if (o_out_data.verdict !== want) begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, want, o_out_data.verdict);
                    failures++;
                end else begin
                    verdict_tally[want]++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------------------

    // With both checks off, as after reset, every request passes whatever its fields hold.
    task automatic test_checks_disabled();
        send_request(32'h0000_0000, 5'd0);
        send_request(32'hFFFF_FFFF, 5'd31);
        send_request(32'h5555_AAAA, 5'h0A);
        send_request(32'hAAAA_5555, 5'h15);
        settle_idle();
    endtask

    // The third repeat inside the window mutes; the mute denies, then runs out, and a late
    // resend of the same code starts the count over.
    task automatic test_repeat_mute();
        program_limits(16'd3, 16'd10, 16'd0, 16'd0, 16'd20);
        send_request(32'd100, 5'd5);
        send_request(32'd102, 5'd5);
        send_request(32'd104, 5'd5);
        send_request(32'd105, 5'd5);
        send_request(32'd110, 5'd5);
        send_request(32'd130, 5'd5);
        send_request(32'd131, 5'd9);
        settle_idle();
    endtask

    // The flood limit is reached inside the window; after the mute, a request outside the
    // window empties the count and the next one opens a fresh window.
    task automatic test_flood_mute();
        program_limits(16'd0, 16'd0, 16'd3, 16'd20, 16'd15);
        send_request(32'd1000, 5'd1);
        send_request(32'd1005, 5'd2);
        send_request(32'd1010, 5'd3);
        send_request(32'd1020, 5'd4);
        send_request(32'd1030, 5'd5);
        send_request(32'd1031, 5'd6);
        settle_idle();
    endtask

    // Register extremes, a mute end that would pass the top of the tick range, time that
    // goes backwards, zero windows, and a mute that would end at tick zero.
    task automatic test_extremes();
        program_limits(16'hFF01, 16'hFFFF, 16'h00FF, 16'h0000, 16'hFFFF);
        send_request(32'hFFFF_FF00, 5'd9);
        send_request(32'hFFFF_FF10, 5'd9);
        send_request(32'hFFFF_FFFE, 5'd3);
        send_request(32'hFFFF_FFFF, 5'd3);
        send_request(32'h1000_0000, 5'd3);
        settle_idle();
        program_limits(16'd255, 16'd0, 16'd1, 16'hFFFF, 16'd0);
        send_request(32'd0, 5'd3);
        send_request(32'd0, 5'd3);
        send_request(32'd0, 5'd3);
        send_request(32'd0, 5'd17);
        settle_idle();
    endtask

    // Both counters run into their ceiling. The repeat count climbs under a high limit,
    // the limit is then lowered beneath it so that it is never met again, and the count
    // sticks at its maximum. A flood limit of two with zero mute length lets the window
    // count climb the same way.
    task automatic test_count_ceiling();
        int i;
        program_limits(16'd200, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        for (i = 0; i < 20; i++)
            send_request(32'd5000, 5'd12);
        settle_idle();
        program_limits(16'd10, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        for (i = 0; i < 250; i++)
            send_request(32'd5000 + 32'(i / 8), 5'd12);
        settle_idle();
        program_limits(16'd0, 16'd0, 16'd2, 16'hFFFF, 16'd0);
        for (i = 0; i < 260; i++)
            send_request(32'd9000, 5'($urandom_range(0, 31)));
        settle_idle();
    endtask

    // ------------------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------------------

    // Limits lean toward small values, so that mutes actually start, with the extremes
    // mixed in and an occasional junk byte above the register.
    function automatic logic [15:0] pick_limit();
        logic [7:0] junk;
        logic [7:0] lim;
        junk = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        case ($urandom_range(0, 9))
            0:       lim = 8'd0;
            1:       lim = 8'd255;
            2:       lim = 8'd1;
            default: lim = 8'($urandom_range(2, 8));
        endcase
        return {junk, lim};
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 120));
        endcase
    endfunction

    function automatic logic [15:0] pick_mute();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    // Most codes come from a small set, so that repeats are common.
    function automatic logic [4:0] pick_code();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 3));
    endfunction

    // Phases of random traffic, each under fresh limits. Most of it is bursts of one code
    // or of mixed codes spaced tightly enough to land inside the windows; the rest is
    // noise: big jumps that let long mutes run out, steps back in time, and ticks anywhere
    // in the 32-bit range.
    task automatic test_random_traffic();
        int quota;
        int sent_here;
        int burst;
        int cap;
        int k;
        logic [4:0] code;
        while (requests_sent < REQUEST_BUDGET) begin
            settle_idle();
            if (requests_sent >= CALM_FROM)
                calm_tail = 1'b1;
            program_limits(pick_limit(), pick_window(), pick_limit(), pick_window(),
                           pick_mute());
            // Some phases run without sender gaps at all.
            gaps_on = ($urandom_range(0, 3) != 0);
            quota = $urandom_range(80, 200);
            sent_here = 0;
            while (sent_here < quota) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        code = pick_code();
                        burst = $urandom_range(2, 12);
                        cap = int'(limiter_cfg.repeat_window) / 3 + 1;
                        for (k = 0; k < burst; k++) begin
                            tick_cursor = tick_cursor + 32'($urandom_range(0, cap));
                            send_request(tick_cursor, code);
                        end
                        sent_here += burst;
                    end
                    6, 7, 8: begin
                        burst = $urandom_range(2, 12);
                        cap = int'(limiter_cfg.flood_window) / 4 + 1;
                        for (k = 0; k < burst; k++) begin
                            tick_cursor = tick_cursor + 32'($urandom_range(0, cap));
                            send_request(tick_cursor, pick_code());
                        end
                        sent_here += burst;
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: tick_cursor = tick_cursor + 32'($urandom_range(100, 70000));
                            1: tick_cursor = tick_cursor - 32'($urandom_range(1, 5000));
                            default: tick_cursor = $urandom;
                        endcase
                        send_request(tick_cursor, 5'($urandom_range(0, 31)));
                        sent_here++;
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_checks_disabled();
        test_repeat_mute();
        test_flood_mute();
        test_extremes();
        test_count_ceiling();
        test_random_traffic();

        // Let the last verdicts drain, then give the pipeline a few cycles to show any
        // verdict that should not be there.
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d requests under %0d register settings.",
                 requests_sent, settings_used);
        $display("Verdicts seen: %0d passed, %0d denied under mute, %0d repeat mutes, %0d flood mutes.",
                 verdict_tally[VERDICT_PASS], verdict_tally[VERDICT_MUTED],
                 verdict_tally[VERDICT_REPEAT], verdict_tally[VERDICT_FLOOD]);
        if (failures == 0 && pending_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mfrl_pkg.sv
hdl/mfrl_decide.sv
hdl/message_flood_and_repeat_limiter.sv
dv/message_flood_and_repeat_limiter_tb.sv
